// ===== design/salsa20_keystream_8block_macros.svh =====
// Assertion macros used by the keystream module
`ifndef SALSA20_KEYSTREAM_8BLOCK_MACROS_SVH
`define SALSA20_KEYSTREAM_8BLOCK_MACROS_SVH

// Implication checked on every rising clock edge, off during reset
`define S20_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define S20_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/s20ks_pkg.sv =====
`default_nettype none
package s20ks_pkg;
    localparam int unsigned BlocksPerRequest = 8;
    localparam int unsigned WordsPerBlock    = 8;
    localparam int unsigned NumCells         = 16;
    localparam int unsigned NumRegs          = 8;
    localparam int unsigned RegIdxW          = 3;
    localparam int unsigned RoundW           = 5;

    localparam logic [RegIdxW-1:0] REG_DIAG_0_5   = 3'd0;
    localparam logic [RegIdxW-1:0] REG_DIAG_10_15 = 3'd1;
    localparam logic [RegIdxW-1:0] REG_KEY_1_2    = 3'd2;
    localparam logic [RegIdxW-1:0] REG_KEY_3_4    = 3'd3;
    localparam logic [RegIdxW-1:0] REG_KEY_11_12  = 3'd4;
    localparam logic [RegIdxW-1:0] REG_KEY_13_14  = 3'd5;
    localparam logic [RegIdxW-1:0] REG_NONCE      = 3'd6;
    localparam logic [RegIdxW-1:0] REG_ROUNDS     = 3'd7;

    localparam logic ACT_GENERATE = 1'b0;
    localparam logic ACT_LOAD     = 1'b1;

    // one step of a quarter round: which word is updated and how far it rotates
    typedef struct packed {
        logic [3:0] dst;
        logic [3:0] src_a;
        logic [3:0] src_b;
        logic [4:0] rot;
    } t_qr_step;

    typedef struct packed {
        logic       load;   // take initial words into cells
        logic       step;   // apply one quarter-round step
        logic       add;    // feed-forward add
        logic       shift;  // shift words two cells toward the output end
    } t_cell_ctl;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

    // 32 steps per double round: 8 quarter rounds of 4 steps each
    function automatic t_qr_step qr_step(input logic [4:0] idx);
        logic [3:0] a, b, c, d;
        t_qr_step   s;
        case (idx[4:2])
            3'd0: begin a = 4'd0;  b = 4'd4;  c = 4'd8;  d = 4'd12; end
            3'd1: begin a = 4'd5;  b = 4'd9;  c = 4'd13; d = 4'd1;  end
            3'd2: begin a = 4'd10; b = 4'd14; c = 4'd2;  d = 4'd6;  end
            3'd3: begin a = 4'd15; b = 4'd3;  c = 4'd7;  d = 4'd11; end
            3'd4: begin a = 4'd0;  b = 4'd1;  c = 4'd2;  d = 4'd3;  end
            3'd5: begin a = 4'd5;  b = 4'd6;  c = 4'd7;  d = 4'd4;  end
            3'd6: begin a = 4'd10; b = 4'd11; c = 4'd8;  d = 4'd9;  end
            default: begin a = 4'd15; b = 4'd12; c = 4'd13; d = 4'd14; end
        endcase
        case (idx[1:0])
            2'd0: s = '{dst: b, src_a: a, src_b: d, rot: 5'd7};
            2'd1: s = '{dst: c, src_a: b, src_b: a, rot: 5'd9};
            2'd2: s = '{dst: d, src_a: c, src_b: b, rot: 5'd13};
            default: s = '{dst: a, src_a: d, src_b: c, rot: 5'd18};
        endcase
        return s;
    endfunction
endpackage
`default_nettype wire

// ===== design/s20ks_cell.sv =====
`default_nettype none
// One state word: holds the working word and its initial value, and hands
// the working word to the neighbor cell during the output shift.
module s20ks_cell (
    input  wire logic                  i_clk,
    input  wire s20ks_pkg::t_cell_ctl  i_ctl,
    input  wire logic [3:0]            i_cell_idx,
    input  wire logic [3:0]            i_step_dst,
    input  wire logic [31:0]           i_step_val,
    input  wire logic [31:0]           i_init,
    input  wire logic [31:0]           i_nbr_word,
    output logic [31:0]                o_word
);
    import s20ks_pkg::*;

    logic [31:0] r_word, n_word;
    logic [31:0] r_init, n_init;

    always_comb begin
        n_word = r_word;
        n_init = r_init;
        if (i_ctl.load) begin
            n_word = i_init;
            n_init = i_init;
        end else if (i_ctl.step && i_step_dst == i_cell_idx) begin
            n_word = r_word ^ i_step_val;
        end else if (i_ctl.add) begin
            n_word = r_word + r_init;
        end else if (i_ctl.shift) begin
            n_word = i_nbr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_init <= n_init;
    end

    assign o_word = r_word;
endmodule
`default_nettype wire

// ===== design/salsa20_keystream_8block.sv =====
`default_nettype none
// Salsa20 keystream generator. A generate request (action 0) produces
// BLOCKS_PER_REQUEST blocks for counters counter..counter+N-1 and streams
// them as 8-byte little-endian words, is_last on the final word; the counter
// then advances by N. A load request (action 1) sets the counter. The state
// lives in a row of sixteen word cells; one quarter-round step (add, rotate,
// xor) runs per cycle. Each block is a load, 32 steps per double round and a
// feed-forward add, then 8 words shifted out, one each time the output
// register is free. One request is taken at a time. The user must write
// configuration only while idle; the block itself does not enforce this.
module salsa20_keystream_8block #(
    parameter int unsigned BLOCKS_PER_REQUEST = s20ks_pkg::BlocksPerRequest
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_action,
    input  wire logic [63:0] i_counter_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_keystream_bytes,
    output logic             o_is_last,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);
    import s20ks_pkg::*;

    localparam int unsigned BlkW = (BLOCKS_PER_REQUEST > 1) ? $clog2(BLOCKS_PER_REQUEST) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state       r_state, n_state;
    logic [63:0]  r_cfg [NumRegs-1];
    logic [RoundW-1:0] r_rounds;
    logic [63:0]  r_counter, n_counter;
    logic [BlkW-1:0] r_blk, n_blk;
    logic [3:0]   r_dr, n_dr;         // double rounds done
    logic [4:0]   r_step, n_step;     // step within double round
    logic [2:0]   r_wcnt, n_wcnt;     // words emitted of this block
    logic         r_ovalid, n_ovalid;
    logic [63:0]  r_obytes, n_obytes;
    logic         r_olast, n_olast;

    t_cell_ctl    w_ctl;
    t_qr_step     w_qs;
    logic [31:0]  w_word [NumCells];
    logic [31:0]  w_init [NumCells];
    logic [31:0]  w_step_val;
    logic [63:0]  w_blk_ctr;
    logic [3:0]   w_ndr;
    logic         w_in_acc;
    logic         w_out_free;

    assign w_ndr      = r_rounds[RoundW-1:1];
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;
    assign o_stall    = (r_state != ST_IDLE);
    assign w_blk_ctr  = r_counter + 64'(r_blk);
    assign w_qs       = qr_step(r_step);
    assign w_step_val = rotl32(w_word[w_qs.src_a] + w_word[w_qs.src_b], w_qs.rot);

    always_comb begin
        w_init[0]  = r_cfg[REG_DIAG_0_5][31:0];
        w_init[5]  = r_cfg[REG_DIAG_0_5][63:32];
        w_init[10] = r_cfg[REG_DIAG_10_15][31:0];
        w_init[15] = r_cfg[REG_DIAG_10_15][63:32];
        w_init[1]  = r_cfg[REG_KEY_1_2][31:0];
        w_init[2]  = r_cfg[REG_KEY_1_2][63:32];
        w_init[3]  = r_cfg[REG_KEY_3_4][31:0];
        w_init[4]  = r_cfg[REG_KEY_3_4][63:32];
        w_init[11] = r_cfg[REG_KEY_11_12][31:0];
        w_init[12] = r_cfg[REG_KEY_11_12][63:32];
        w_init[13] = r_cfg[REG_KEY_13_14][31:0];
        w_init[14] = r_cfg[REG_KEY_13_14][63:32];
        w_init[6]  = r_cfg[REG_NONCE][31:0];
        w_init[7]  = r_cfg[REG_NONCE][63:32];
        w_init[8]  = w_blk_ctr[31:0];
        w_init[9]  = w_blk_ctr[63:32];
    end

    genvar gi;
    generate
        for (gi = 0; gi < NumCells; gi++) begin : g_cell
            logic [31:0] w_nbr;
            if (gi + 2 < NumCells) begin : g_mid
                assign w_nbr = w_word[gi + 2];
            end else begin : g_end
                assign w_nbr = 32'd0;
            end
            s20ks_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_cell_idx (4'(gi)),
                .i_step_dst (w_qs.dst),
                .i_step_val (w_step_val),
                .i_init     (w_init[gi]),
                .i_nbr_word (w_nbr),
                .o_word     (w_word[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state   = r_state;
        n_counter = r_counter;
        n_blk     = r_blk;
        n_dr      = r_dr;
        n_step    = r_step;
        n_wcnt    = r_wcnt;
        n_ovalid  = r_ovalid;
        n_obytes  = r_obytes;
        n_olast   = r_olast;
        w_ctl     = '0;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_action == ACT_LOAD) begin
                        n_counter = i_counter_value;
                    end else begin
                        n_blk   = '0;
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                w_ctl.load = 1'b1;
                n_dr       = '0;
                n_step     = '0;
                n_state    = (w_ndr == 4'd0) ? ST_ADD : ST_ROUND;
            end
            ST_ROUND: begin
                w_ctl.step = 1'b1;
                n_step     = r_step + 5'd1;
                if (r_step == 5'd31) begin
                    n_dr = r_dr + 4'd1;
                    if (r_dr + 4'd1 == w_ndr) begin
                        n_state = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                w_ctl.add = 1'b1;
                n_wcnt    = '0;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_ctl.shift = 1'b1;
                    n_ovalid    = 1'b1;
                    n_obytes    = {w_word[1], w_word[0]};
                    n_olast     = (r_wcnt == 3'd7) &&
                                  (32'(r_blk) == BLOCKS_PER_REQUEST - 1);
                    n_wcnt      = r_wcnt + 3'd1;
                    if (r_wcnt == 3'd7) begin
                        if (32'(r_blk) == BLOCKS_PER_REQUEST - 1) begin
                            n_counter = r_counter + 64'(BLOCKS_PER_REQUEST);
                            n_state   = ST_IDLE;
                        end else begin
                            n_blk   = r_blk + BlkW'(1);
                            n_state = ST_LOAD;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_counter <= '0;
            r_ovalid  <= 1'b0;
            r_rounds  <= RoundW'(20);
            for (int k = 0; k < NumRegs - 1; k++) begin
                r_cfg[k] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_counter <= n_counter;
            r_ovalid  <= n_ovalid;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ROUNDS) begin
                    r_rounds <= i_cfg_data[RoundW-1:0];
                end else begin
                    r_cfg[i_cfg_idx] <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk    <= n_blk;
        r_dr     <= n_dr;
        r_step   <= n_step;
        r_wcnt   <= n_wcnt;
        r_obytes <= n_obytes;
        r_olast  <= n_olast;
    end

    assign o_valid           = r_ovalid;
    assign o_keystream_bytes = r_obytes;
    assign o_is_last         = r_olast;

    `include "salsa20_keystream_8block_macros.svh"

    `S20_ASSERT_IMP(a_busy_stalls, i_clk, i_rst_n, r_state != ST_IDLE, o_stall, "busy but not stalling")
    `S20_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, r_ovalid && i_stall, r_ovalid && $stable(r_obytes), "output dropped while stalled")
    `S20_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, r_state == ST_EMIT && n_olast && w_out_free, r_state == ST_IDLE, "last word without return to idle")
endmodule
`default_nettype wire

// ===== sim/salsa20_keystream_8block_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module salsa20_keystream_8block_tb;
    import s20ks_pkg::*;

    typedef struct {
        logic [63:0] bytes;
        logic        last;
    } t_ks_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_action = ACT_GENERATE;
    logic [63:0] i_counter_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_keystream_bytes;
    logic        o_is_last;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = REG_DIAG_0_5;
    logic [63:0] i_cfg_data = '0;

    salsa20_keystream_8block dut (.*);

    logic [63:0] cfg_regs [NumRegs];
    logic [63:0] blk_ctr;
    t_ks_word    ks_expected [$];
    int          fail_cnt = 0;
    longint      cycle_cnt = 0;

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 64'd60_000_000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] rol(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void quarter(ref logic [31:0] x[16], input int a, b, c, d);
        x[b] ^= rol(x[a] + x[d], 7);
        x[c] ^= rol(x[b] + x[a], 9);
        x[d] ^= rol(x[c] + x[b], 13);
        x[a] ^= rol(x[d] + x[c], 18);
    endfunction

    // expand one request into 64 keystream words and advance the counter
    function automatic void predict_keystream();
        logic [31:0] init[16];
        logic [31:0] x[16];
        logic [63:0] c;
        int          dr;
        {init[5], init[0]}   = cfg_regs[REG_DIAG_0_5];
        {init[15], init[10]} = cfg_regs[REG_DIAG_10_15];
        {init[2], init[1]}   = cfg_regs[REG_KEY_1_2];
        {init[4], init[3]}   = cfg_regs[REG_KEY_3_4];
        {init[12], init[11]} = cfg_regs[REG_KEY_11_12];
        {init[14], init[13]} = cfg_regs[REG_KEY_13_14];
        {init[7], init[6]}   = cfg_regs[REG_NONCE];
        dr = cfg_regs[REG_ROUNDS][4:1];
        for (int b = 0; b < BlocksPerRequest; b++) begin
            c = blk_ctr + 64'(b);
            {init[9], init[8]} = c;
            x = init;
            for (int r = 0; r < dr; r++) begin
                quarter(x, 0, 4, 8, 12);
                quarter(x, 5, 9, 13, 1);
                quarter(x, 10, 14, 2, 6);
                quarter(x, 15, 3, 7, 11);
                quarter(x, 0, 1, 2, 3);
                quarter(x, 5, 6, 7, 4);
                quarter(x, 10, 11, 8, 9);
                quarter(x, 15, 12, 13, 14);
            end
            for (int k = 0; k < 16; k++) x[k] += init[k];
            for (int k = 0; k < WordsPerBlock; k++)
                ks_expected.push_back('{{x[2*k+1], x[2*k]},
                    (b == BlocksPerRequest - 1) && (k == WordsPerBlock - 1)});
        end
        blk_ctr += 64'(BlocksPerRequest);
    endfunction

    // valid stays high after acceptance; drop it only when idling or draining
    task automatic send_request(logic act, logic [63:0] ctr);
        int idle;
        idle = $urandom_range(0, 7);
        if (idle > 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_counter_value <= ctr;
        do @(posedge i_clk); while (o_stall);
        if (act == ACT_LOAD) blk_ctr = ctr;
        else predict_keystream();
    endtask

    // receiver: random stall per word
    initial begin
        t_ks_word e;
        int       hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                if (ks_expected.size() == 0) begin
                    $error("keystream word with nothing expected");
                    fail_cnt++;
                end else begin
                    e = ks_expected.pop_front();
                    if (o_keystream_bytes !== e.bytes) begin
                        $error("keystream_bytes exp %h got %h", e.bytes, o_keystream_bytes);
                        fail_cnt++;
                    end
                    if (o_is_last !== e.last) begin
                        $error("is_last exp %b got %b", e.last, o_is_last);
                        fail_cnt++;
                    end
                end
                hold = $urandom_range(0, 7);
                if ($urandom_range(0, 3) == 0) hold = 0;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                hold--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic drain();
        i_valid <= 1'b0;
        while (ks_expected.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_regs[idx] = (idx == REG_ROUNDS) ? (val & 64'h1f) : val;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_key(int rounds);
        for (int i = 0; i < 7; i++) write_reg(3'(i), rand64());
        write_reg(REG_ROUNDS, 64'(rounds));
    endtask

    task automatic test_reset_defaults();
        send_request(ACT_GENERATE, rand64());
        send_request(ACT_GENERATE, '0);
        drain();
    endtask

    task automatic test_extremes();
        for (int i = 0; i < 7; i++) write_reg(3'(i), '1);
        write_reg(REG_ROUNDS, 64'd0);
        send_request(ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFC);
        send_request(ACT_GENERATE, '1);
        send_request(ACT_GENERATE, '0);
        drain();
        write_reg(REG_ROUNDS, 64'd1);
        send_request(ACT_LOAD, 64'h0000_0000_FFFF_FFFE);
        send_request(ACT_GENERATE, '0);
        drain();
        for (int i = 0; i < 7; i++) write_reg(3'(i), '0);
        write_reg(REG_ROUNDS, 64'd31);
        send_request(ACT_LOAD, '0);
        send_request(ACT_GENERATE, '1);
        drain();
        random_key(21);
        send_request(ACT_LOAD, '1);
        send_request(ACT_GENERATE, rand64());
        drain();
    endtask

    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                drain();
                r = (i % 120 == 0) ? 2 * $urandom_range(0, 10) : $urandom_range(0, 31);
                random_key(r);
            end
            if ($urandom_range(0, 3) == 0)
                send_request(ACT_LOAD, ($urandom_range(0, 1) ? rand64()
                    : 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 15))));
            else
                send_request(ACT_GENERATE, rand64());
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < NumRegs; i++) cfg_regs[i] = '0;
        cfg_regs[REG_ROUNDS] = 64'd20;
        blk_ctr = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_extremes();
        test_random(400);
        if (fail_cnt == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
